FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst_n is low.
`define RRQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define RRQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rrqs_pkg.sv
package rrqs_pkg;

  localparam int MAX_TASKS  = 16;
  localparam int TASK_LIMIT = 15;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int TIME_W     = 20;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;

  localparam logic [7:0] QUANTUM_RESET = 8'd2;
  localparam int         PADDR_W       = 3;
  localparam logic       REG_QUANTUM   = 1'b0;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  task_id;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              task_finished;
  } res_t;

endpackage

FILE: src/round_robin_quantum_scheduler_unit.sv
// Channel   | Handshake                      | Payload
// in_       | in_valid / in_ready            | in_opcode, in_arrival_time, in_burst_time
// out_      | out_valid / out_ready          | out_status, out_task_id, out_slice_start,
//           |                                | out_slice_end, out_task_finished
// cfg (APB) | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One word is handled at a time by a sequencer around four small synchronous memories.
// A load walks the new task down past later arrivals, one read and one compare per task passed.
// A run slice admits arrived tasks, one read and one compare each, jumping time to the next
// arrival when none is ready; a run with no work reports idle without taking a slice.
// Reset is synchronous and active low; it clears all counters and the queue pointers.
// A result that is not taken holds the sequencer; the next word is accepted once it is stored.
module round_robin_quantum_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [15:0]                   in_arrival_time,
  input  logic [7:0]                    in_burst_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [3:0]                    out_task_id,
  output logic [19:0]                   out_slice_start,
  output logic [19:0]                   out_slice_end,
  output logic                          out_task_finished,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrqs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic           core_idle, res_valid, out_free;
  logic [7:0]     quantum;
  rrqs_pkg::res_t res, out_r;
  logic           out_valid_r;

  rrqs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quantum (quantum)
  );

  rrqs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_valid && in_ready),
    .opcode       (in_opcode),
    .arrival_time (in_arrival_time),
    .burst_time   (in_burst_time),
    .quantum      (quantum),
    .out_free     (out_free),
    .idle         (core_idle),
    .res_valid    (res_valid),
    .res          (res)
  );

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = core_idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_task_id       = out_r.task_id;
  assign out_slice_start   = out_r.slice_start;
  assign out_slice_end     = out_r.slice_end;
  assign out_task_finished = out_r.task_finished;

endmodule

FILE: src/rrqs_cfg.sv
module rrqs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrqs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [7:0]                    quantum
);

  logic [7:0] quantum_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == rrqs_pkg::REG_QUANTUM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= rrqs_pkg::QUANTUM_RESET;
    end else if (wr_en) begin
      quantum_r <= pwdata[7:0];
    end
  end

  // Only the quantum register exists, decoded from paddr[2] alone; addresses with paddr[2] set read as zero.
  assign prdata  = (paddr[2] == rrqs_pkg::REG_QUANTUM) ? {24'd0, quantum_r} : 32'd0;
  assign quantum = quantum_r;

endmodule

FILE: src/rrqs_core.sv
`include "assert_macros.svh"

module rrqs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  logic [15:0]       arrival_time,
  input  logic [7:0]        burst_time,
  input  logic [7:0]        quantum,
  input  logic              out_free,
  output logic              idle,
  output logic              res_valid,
  output rrqs_pkg::res_t    res
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_ADM_RD  = 4'd3;
  localparam logic [3:0] S_ADM_CHK = 4'd4;
  localparam logic [3:0] S_JMP_RD  = 4'd5;
  localparam logic [3:0] S_JMP     = 4'd6;
  localparam logic [3:0] S_SEL     = 4'd7;
  localparam logic [3:0] S_POP     = 4'd8;
  localparam logic [3:0] S_CALC    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_JUMP  = 2'd1;
  localparam logic [1:0] PH_POST  = 2'd2;

  localparam int IW = rrqs_pkg::IDX_W;
  localparam int CW = rrqs_pkg::CNT_W;
  localparam int TW = rrqs_pkg::TIME_W;

  // Task ids sorted by arrival, with the matching arrival times alongside.
  logic [IW-1:0] order_mem  [rrqs_pkg::MAX_TASKS];
  logic [15:0]   sorted_mem [rrqs_pkg::MAX_TASKS];
  logic [7:0]    rem_mem    [rrqs_pkg::MAX_TASKS];
  logic [IW-1:0] fifo_mem   [rrqs_pkg::MAX_TASKS];

  logic [IW-1:0] order_q, fifo_q;
  logic [15:0]   sorted_q;
  logic [7:0]    rem_q;

  logic          ord_we, rem_we, fifo_we;
  logic [IW-1:0] ord_wa, ord_ra, rem_wa, rem_ra, fifo_wa, fifo_ra;
  logic [IW-1:0] ord_wd, fifo_wd;
  logic [15:0]   srt_wd;
  logic [7:0]    rem_wd;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, rcount_r, rcount_nxt, next_r, next_nxt, left_r, left_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] head_r, head_nxt, id_r, id_nxt;
  logic [TW-1:0] time_r, time_nxt;
  logic          running_r, running_nxt;
  logic [15:0]   arr_r, arr_nxt;
  logic [7:0]    burst_r, burst_nxt, remnew_r, remnew_nxt;
  rrqs_pkg::res_t res_r, res_nxt;

  logic [3:0]    adm_done_st;
  logic [7:0]    q_eff, run_len;

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_wa]  <= ord_wd;
      sorted_mem[ord_wa] <= srt_wd;
    end
    order_q  <= order_mem[ord_ra];
    sorted_q <= sorted_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    rem_q <= rem_mem[rem_ra];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_wa] <= fifo_wd;
    end
    fifo_q <= fifo_mem[fifo_ra];
  end

  assign q_eff   = (quantum == 8'd0) ? 8'd1 : quantum;
  assign run_len = (rem_q < q_eff) ? rem_q : q_eff;

  // Where an admission pass goes once it stops.
  always_comb begin
    case (phase_r)
      PH_FIRST: adm_done_st = (rcount_r == '0 && next_r < cnt_r) ? S_JMP_RD : S_SEL;
      PH_JUMP:  adm_done_st = S_SEL;
      default:  adm_done_st = S_FIN;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    rcount_nxt  = rcount_r;
    next_nxt    = next_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    head_nxt    = head_r;
    id_nxt      = id_r;
    time_nxt    = time_r;
    running_nxt = running_r;
    arr_nxt     = arr_r;
    burst_nxt   = burst_r;
    remnew_nxt  = remnew_r;
    res_nxt     = res_r;
    ord_we  = 1'b0;
    ord_wa  = pos_r[IW-1:0];
    ord_wd  = id_r;
    srt_wd  = arr_r;
    ord_ra  = next_r[IW-1:0];
    rem_we  = 1'b0;
    rem_wa  = id_r;
    rem_wd  = burst_r;
    rem_ra  = fifo_q;
    fifo_we = 1'b0;
    fifo_wa = head_r + rcount_r[IW-1:0];
    fifo_wd = order_q;
    fifo_ra = head_r;
    res_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt = '0;
          case (opcode)
            rrqs_pkg::OP_LOAD: begin
              if (running_r || cnt_r >= CW'(rrqs_pkg::TASK_LIMIT)) begin
                res_nxt.status = rrqs_pkg::ST_REFUSED;
                state_nxt = S_DONE;
              end else begin
                id_nxt    = cnt_r[IW-1:0];
                pos_nxt   = cnt_r;
                arr_nxt   = arrival_time;
                burst_nxt = burst_time;
                state_nxt = S_INS_RD;
              end
            end
            rrqs_pkg::OP_RUN: begin
              running_nxt = 1'b1;
              phase_nxt   = PH_FIRST;
              state_nxt   = S_ADM_RD;
            end
            rrqs_pkg::OP_CLEAR: begin
              cnt_nxt     = '0;
              rcount_nxt  = '0;
              next_nxt    = '0;
              left_nxt    = '0;
              head_nxt    = '0;
              time_nxt    = '0;
              running_nxt = 1'b0;
              state_nxt   = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_RD: begin
        ord_ra = pos_r[IW-1:0] - 1'b1;
        if (pos_r == '0) begin
          ord_we = 1'b1;
          rem_we = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          left_nxt = left_r + 1'b1;
          res_nxt.task_id = id_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sorted_q > arr_r) begin
          // Shift the later entry up one place and keep walking down.
          ord_we  = 1'b1;
          ord_wd  = order_q;
          srt_wd  = sorted_q;
          pos_nxt = pos_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          ord_we = 1'b1;
          rem_we = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          left_nxt = left_r + 1'b1;
          res_nxt.task_id = id_r;
          state_nxt = S_DONE;
        end
      end
      S_ADM_RD: begin
        state_nxt = (next_r < cnt_r) ? S_ADM_CHK : adm_done_st;
      end
      S_ADM_CHK: begin
        if ({4'd0, sorted_q} > time_r) begin
          state_nxt = adm_done_st;
        end else begin
          fifo_we    = 1'b1;
          rcount_nxt = rcount_r + 1'b1;
          next_nxt   = next_r + 1'b1;
          state_nxt  = S_ADM_RD;
        end
      end
      S_JMP_RD: begin
        state_nxt = S_JMP;
      end
      S_JMP: begin
        time_nxt  = {4'd0, sorted_q};
        phase_nxt = PH_JUMP;
        state_nxt = S_ADM_RD;
      end
      S_SEL: begin
        if (left_r == '0 || rcount_r == '0) begin
          res_nxt.status      = rrqs_pkg::ST_IDLE;
          res_nxt.slice_start = time_r;
          res_nxt.slice_end   = time_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        id_nxt     = fifo_q;
        head_nxt   = head_r + 1'b1;
        rcount_nxt = rcount_r - 1'b1;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        rem_we     = 1'b1;
        rem_wd     = rem_q - run_len;
        remnew_nxt = rem_q - run_len;
        res_nxt.slice_start = time_r;
        time_nxt   = time_r + {12'd0, run_len};
        phase_nxt  = PH_POST;
        state_nxt  = S_ADM_RD;
      end
      S_FIN: begin
        res_nxt.task_id   = id_r;
        res_nxt.slice_end = time_r;
        if (remnew_r != 8'd0) begin
          fifo_we    = 1'b1;
          fifo_wd    = id_r;
          rcount_nxt = rcount_r + 1'b1;
        end else begin
          res_nxt.task_finished = 1'b1;
          left_nxt = left_r - 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_FIRST;
      cnt_r     <= '0;
      rcount_r  <= '0;
      next_r    <= '0;
      left_r    <= '0;
      head_r    <= '0;
      time_r    <= '0;
      running_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      rcount_r  <= rcount_nxt;
      next_r    <= next_nxt;
      left_r    <= left_nxt;
      head_r    <= head_nxt;
      time_r    <= time_nxt;
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    id_r     <= id_nxt;
    arr_r    <= arr_nxt;
    burst_r  <= burst_nxt;
    remnew_r <= remnew_nxt;
    res_r    <= res_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign res  = res_r;

  `RRQS_ASSERT(a_admit_bound, next_r <= cnt_r, "admission pointer passed the task count")
  `RRQS_ASSERT(a_queue_bound, (rcount_r + left_r) <= (cnt_r + cnt_r), "ready queue overflow")
  `RRQS_ASSERT(a_load_growth, (cnt_r != $past(cnt_r)) |-> (state_nxt == S_IDLE || state_r == S_DONE), "task count moved outside a load")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Checks the round-robin scheduler word by word against a behavioral
// scheduler kept in this module. Directed tests cover loads, refusals, clears,
// zero bursts and equal arrivals. Random schedules of loads followed by run
// slices then fill most of the run, covering time jumps and the quantum extremes.
module tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [15:0] in_arrival_time;
  logic [7:0]  in_burst_time;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [3:0]  out_task_id;
  logic [19:0] out_slice_start;
  logic [19:0] out_slice_end;
  logic        out_task_finished;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [rrqs_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  round_robin_quantum_scheduler_unit dut (.*);

  // Scheduler state as the block should hold it.
  logic [7:0]  sched_quantum;
  logic [15:0] task_arrival [rrqs_pkg::MAX_TASKS];
  logic [7:0]  task_remaining [rrqs_pkg::MAX_TASKS];
  logic [3:0]  sorted_ids [rrqs_pkg::MAX_TASKS];
  logic [3:0]  ready_ring [rrqs_pkg::MAX_TASKS];
  int unsigned ring_count, ring_head, loaded, admitted, unfinished;
  logic [19:0] now;
  logic        started;

  rrqs_pkg::res_t expected_words [$];
  int          error_count;
  int          sent_count;
  bit          idle_enable;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic clear_schedule();
    for (int i = 0; i < rrqs_pkg::MAX_TASKS; i++) begin
      task_arrival[i] = '0;
      task_remaining[i] = '0;
      sorted_ids[i] = '0;
      ready_ring[i] = '0;
    end
    ring_count = 0;
    ring_head = 0;
    loaded = 0;
    admitted = 0;
    unfinished = 0;
    now = '0;
    started = 1'b0;
  endtask

  task automatic enqueue_ready(input logic [3:0] id);
    if (ring_count < rrqs_pkg::MAX_TASKS) begin
      ready_ring[(ring_head + ring_count) % rrqs_pkg::MAX_TASKS] = id;
      ring_count++;
    end
  endtask

  // Move every loaded task whose arrival has been reached into the ring.
  task automatic admit_arrivals();
    while (admitted < loaded) begin
      if (20'(task_arrival[sorted_ids[admitted]]) > now) break;
      enqueue_ready(sorted_ids[admitted]);
      admitted++;
    end
  endtask

  // Works out the one result word that an input word produces.
  task automatic schedule_word(input logic [1:0] op, input logic [15:0] arr,
                               input logic [7:0] burst, output rrqs_pkg::res_t r);
    int unsigned pos;
    logic [7:0] q, slice;
    logic [3:0] id;
    r = '0;
    if (op == rrqs_pkg::OP_LOAD) begin
      if (started || loaded >= rrqs_pkg::TASK_LIMIT) begin
        r.status = rrqs_pkg::ST_REFUSED;
      end else begin
        id = 4'(loaded);
        r.task_id = id;
        task_arrival[id] = arr;
        task_remaining[id] = burst;
        // Stable insertion: equal arrivals keep their load order.
        pos = loaded;
        while (pos > 0 && task_arrival[sorted_ids[pos-1]] > arr) begin
          sorted_ids[pos] = sorted_ids[pos-1];
          pos--;
        end
        sorted_ids[pos] = id;
        loaded++;
        unfinished++;
      end
    end else if (op == rrqs_pkg::OP_RUN) begin
      started = 1'b1;
      admit_arrivals();
      if (ring_count == 0 && admitted < loaded) begin
        // Idle CPU: jump ahead to the next arrival.
        now = 20'(task_arrival[sorted_ids[admitted]]);
        admit_arrivals();
      end
      if (unfinished == 0 || ring_count == 0) begin
        r.status = rrqs_pkg::ST_IDLE;
        r.slice_start = now;
        r.slice_end = now;
      end else begin
        q = (sched_quantum == 0) ? 8'd1 : sched_quantum;
        id = ready_ring[ring_head];
        ring_head = (ring_head + 1) % rrqs_pkg::MAX_TASKS;
        ring_count--;
        slice = (task_remaining[id] < q) ? task_remaining[id] : q;
        r.task_id = id;
        r.slice_start = now;
        now = now + 20'(slice);
        r.slice_end = now;
        task_remaining[id] -= slice;
        // New arrivals go ahead of the preempted task.
        admit_arrivals();
        if (task_remaining[id] > 0) begin
          enqueue_ready(id);
        end else begin
          r.task_finished = 1'b1;
          unfinished--;
        end
      end
    end else if (op == rrqs_pkg::OP_CLEAR) begin
      clear_schedule();
    end
  endtask

  // Long bursts only where the quantum is large enough to keep slice counts modest.
  function automatic logic [7:0] pick_burst();
    if (sched_quantum >= 8'd16 && $urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 9));
  endfunction

  task automatic maybe_gap();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Sends one word, holding it until the block accepts it.
  task automatic send_word(input logic [1:0] op, input logic [15:0] arr,
                           input logic [7:0] burst);
    rrqs_pkg::res_t r;
    maybe_gap();
    schedule_word(op, arr, burst, r);
    expected_words.push_back(r);
    sent_count++;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_arrival_time <= arr;
    in_burst_time <= burst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // The register is written only when no word is in flight.
  task automatic write_quantum(input logic [7:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= rrqs_pkg::PADDR_W'(4 * rrqs_pkg::REG_QUANTUM);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sched_quantum = value;
  endtask

  task automatic run_slices(input int n);
    for (int i = 0; i < n; i++) send_word(rrqs_pkg::OP_RUN, '0, '0);
  endtask

  task automatic test_directed_loads();
    send_word(rrqs_pkg::OP_LOAD, 16'd5, 8'd3);
    send_word(rrqs_pkg::OP_LOAD, 16'd0, 8'd255);
    send_word(rrqs_pkg::OP_LOAD, 16'd5, 8'd0);
    send_word(rrqs_pkg::OP_LOAD, 16'hFFFF, 8'd1);
    send_word(rrqs_pkg::OP_NOP, 16'hFFFF, 8'hFF);
    run_slices(4);
    // Loading after the first run slice is refused.
    send_word(rrqs_pkg::OP_LOAD, 16'd1, 8'd1);
    send_word(rrqs_pkg::OP_CLEAR, '0, '0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < rrqs_pkg::TASK_LIMIT + 2; i++)
      send_word(rrqs_pkg::OP_LOAD, 16'(i % 3), 8'(i));
    run_slices(3);
    send_word(rrqs_pkg::OP_CLEAR, '0, '0);
    // Running with nothing loaded reports no work left.
    run_slices(1);
    send_word(rrqs_pkg::OP_CLEAR, '0, '0);
  endtask

  // A schedule: 1 to TASK_LIMIT loads, sometimes one extra, then enough slices to finish them and one more.
  task automatic random_schedule();
    int n;
    int unsigned span;
    n = $urandom_range(1, rrqs_pkg::TASK_LIMIT);
    span = ($urandom_range(0, 3) == 0) ? 65535 : 40;
    for (int i = 0; i < n; i++)
      send_word(rrqs_pkg::OP_LOAD, 16'($urandom_range(0, span)), pick_burst());
    if ($urandom_range(0, 7) == 0) send_word(rrqs_pkg::OP_LOAD, 16'($urandom), pick_burst());
    while (unfinished != 0) run_slices(1);
    run_slices(1);
    if ($urandom_range(0, 5) == 0)
      send_word(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
    send_word(rrqs_pkg::OP_CLEAR, '0, '0);
  endtask

  task automatic test_random(input int words);
    int start_count;
    start_count = sent_count;
    while (sent_count - start_count < words) random_schedule();
  endtask

  // Result checker: compares each accepted word with the oldest expectation.
  always @(posedge clk) begin
    rrqs_pkg::res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word");
        error_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          error_count++;
        end
        if (out_task_id !== e.task_id) begin
          $error("task_id: expected %0d actual %0d", e.task_id, out_task_id);
          error_count++;
        end
        if (out_slice_start !== e.slice_start) begin
          $error("slice_start: expected %0d actual %0d", e.slice_start, out_slice_start);
          error_count++;
        end
        if (out_slice_end !== e.slice_end) begin
          $error("slice_end: expected %0d actual %0d", e.slice_end, out_slice_end);
          error_count++;
        end
        if (out_task_finished !== e.task_finished) begin
          $error("task_finished: expected %0d actual %0d", e.task_finished,
                 out_task_finished);
          error_count++;
        end
      end
    end
  end

  // Receiver stalls in bursts while idling is enabled.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    error_count = 0;
    sent_count = 0;
    idle_enable = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = rrqs_pkg::OP_LOAD;
    in_arrival_time = '0;
    in_burst_time = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sched_quantum = rrqs_pkg::QUANTUM_RESET;
    clear_schedule();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_loads();
    test_full_table();
    idle_enable = 1'b1;
    write_quantum(8'd255);
    test_random(150);
    write_quantum(8'd0);
    test_random(120);
    write_quantum(8'd1);
    test_random(150);
    write_quantum(8'($urandom_range(2, 9)));
    test_random(150);
    idle_enable = 1'b0;
    test_random(130);
    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/rrqs_pkg.sv
src/rrqs_cfg.sv
src/rrqs_core.sv
src/round_robin_quantum_scheduler_unit.sv
tb/tb.sv
